// ----- rtl/apus_pkg.sv -----
// Shared types and constants for the agent priority update and sort block.
`default_nettype none

package apus_pkg;

  localparam int MAX_AGENTS_DEF    = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int DIST_W  = 16;
  localparam int PRIO_W  = 32;
  localparam int GROUP_W = 7;
  localparam int IDX_W   = 6;

  localparam logic [PRIO_W-1:0] PRIO_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_INSERT,
    ST_EMIT
  } apus_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic insert;
    logic emit;
  } apus_cmd_t;

  typedef struct packed {
    logic div_last;
    logic count_zero;
    logic count_one;
    logic last_item;
  } apus_status_t;

endpackage

`default_nettype wire

// ----- rtl/apus_ctrl.sv -----
// Controller state machine that sequences load, division, insertion and emission.
`default_nettype none

module apus_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  has_parent,
  input  wire apus_pkg::apus_status_t status,
  output apus_pkg::apus_cmd_t        cmd,
  output logic                       busy
);
  import apus_pkg::*;

  apus_state_t state;
  apus_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = has_parent ? ST_INSERT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_next = status.last_item ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.count_zero || status.count_one) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = !status.count_zero;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/apus_datapath.sv -----
// Datapath with priority computation, serial divider, sorted cell row and result registers.
`default_nettype none

module apus_datapath #(
  parameter int MAX_AGENTS    = apus_pkg::MAX_AGENTS_DEF,
  parameter int FRACTION_BITS = apus_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire apus_pkg::apus_cmd_t          cmd,
  output apus_pkg::apus_status_t            status,
  input  wire logic [apus_pkg::DIST_W-1:0]  distance_to_goal,
  input  wire logic [apus_pkg::PRIO_W-1:0]  parent_priority,
  input  wire logic                         has_parent,
  input  wire logic [apus_pkg::GROUP_W-1:0] group_size,
  input  wire logic                         last_agent,
  output logic                              result_valid,
  output logic [apus_pkg::IDX_W-1:0]        agent_index,
  output logic [apus_pkg::PRIO_W-1:0]       agent_priority,
  output logic                              last_result
);
  import apus_pkg::*;

  localparam int DW    = DIST_W + FRACTION_BITS;
  localparam int QW    = (DW > PRIO_W) ? DW : PRIO_W;
  localparam int SC_W  = $clog2(DW);
  localparam int CNT_W = $clog2(MAX_AGENTS + 1);

  logic [DW-1:0]      dq;
  logic [GROUP_W-1:0] rem;
  logic [GROUP_W-1:0] divisor;
  logic [SC_W-1:0]    step_cnt;
  logic [PRIO_W-1:0]  direct_prio;
  logic               root;
  logic               last_item;
  logic [CNT_W-1:0]   count;

  logic [PRIO_W-1:0]  cell_prio [MAX_AGENTS];
  logic [IDX_W-1:0]   cell_idx  [MAX_AGENTS];
  logic [MAX_AGENTS-1:0] gt;
  logic [MAX_AGENTS-1:0] at_count;

  logic [GROUP_W:0]   rem_shift;
  logic               q_bit;
  logic [QW:0]        qext;
  logic [PRIO_W-1:0]  quot_sat;
  logic [PRIO_W-1:0]  ins_prio;
  logic [IDX_W-1:0]   ins_idx;
  logic               do_insert;
  logic [PRIO_W:0]    plus_one;
  logic [PRIO_W-1:0]  frac_mask;

  assign rem_shift = {rem, dq[DW-1]};
  assign q_bit     = rem_shift >= {1'b0, divisor};
  assign qext      = (QW + 1)'(dq);
  assign quot_sat  = (qext > (QW + 1)'(PRIO_MAX)) ? PRIO_MAX : qext[PRIO_W-1:0];
  assign ins_prio  = root ? quot_sat : direct_prio;
  assign ins_idx   = IDX_W'(count);
  assign do_insert = cmd.insert && (count < CNT_W'(MAX_AGENTS));
  assign plus_one  = {1'b0, parent_priority} + ((PRIO_W + 1)'(1) << FRACTION_BITS);
  assign frac_mask = (PRIO_W'(1) << FRACTION_BITS) - PRIO_W'(1);

  assign status.div_last   = step_cnt == SC_W'(DW - 1);
  assign status.count_zero = count == '0;
  assign status.count_one  = count == CNT_W'(1);
  assign status.last_item  = last_item;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      root      <= !has_parent;
      last_item <= last_agent;
      dq        <= DW'(distance_to_goal) << FRACTION_BITS;
      rem       <= '0;
      step_cnt  <= '0;
      divisor   <= (group_size == '0) ? GROUP_W'(1) : group_size;
      if (distance_to_goal != '0) begin
        direct_prio <= plus_one[PRIO_W] ? PRIO_MAX : plus_one[PRIO_W-1:0];
      end else begin
        direct_prio <= parent_priority & frac_mask;
      end
    end else if (cmd.div_step) begin
      dq       <= {dq[DW-2:0], q_bit};
      rem      <= q_bit ? GROUP_W'(rem_shift - {1'b0, divisor}) : rem_shift[GROUP_W-1:0];
      step_cnt <= step_cnt + SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.emit) begin
      count <= count - CNT_W'(1);
    end
  end

  for (genvar k = 0; k < MAX_AGENTS; k++) begin : g_cell
    logic prev_gt;
    logic take;

    assign gt[k]       = (CNT_W'(k) < count) && (ins_prio > cell_prio[k]);
    assign at_count[k] = CNT_W'(k) == count;
    assign take        = gt[k] || at_count[k];

    if (k == 0) begin : g_first
      assign prev_gt = 1'b0;
    end else begin : g_rest
      assign prev_gt = gt[k-1];
    end

    always_ff @(posedge clk) begin
      if (do_insert && take) begin
        if (!prev_gt) begin
          cell_prio[k] <= ins_prio;
          cell_idx[k]  <= ins_idx;
        end else begin
          cell_prio[k] <= cell_prio[(k == 0) ? 0 : k - 1];
          cell_idx[k]  <= cell_idx[(k == 0) ? 0 : k - 1];
        end
      end else if (cmd.emit && (k < MAX_AGENTS - 1)) begin
        cell_prio[k] <= cell_prio[(k < MAX_AGENTS - 1) ? k + 1 : k];
        cell_idx[k]  <= cell_idx[(k < MAX_AGENTS - 1) ? k + 1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      agent_index    <= cell_idx[0];
      agent_priority <= cell_prio[0];
      last_result    <= count == CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/agent_priority_update_and_sort_top.sv -----
// Top level of the agent priority update and sort block.
`default_nettype none

// Usage: an agent transaction is accepted when start is high and busy is low,
// with its fields on distance_to_goal, parent_priority, has_parent,
// group_size and last_agent. Agents arrive in index order for one node.
// An agent with a parent goes from idle straight to the insert state, with no
// division, and the block takes no new agent until busy falls again.
// A root agent runs a restoring divider one quotient bit per cycle, so busy
// stays high through the divide and insert states, and the next transaction
// can be accepted once busy falls again.
// Each priority is inserted into a row of compare-and-shift cells that keeps
// the agents sorted by descending priority, ties by lower index.
// On the transaction marked last, the row shifts out one agent per cycle:
// each result is held for exactly one cycle with result_valid high, and the
// final one carries last_result. A node of n agents emits n results, the
// first registered once the insert state has handed over to the emit state.
// Agents beyond MAX_AGENTS are dropped. The receiver cannot stall the output.
// Reset empties the row and returns the controller to idle.

module agent_priority_update_and_sort_top #(
  parameter int MAX_AGENTS    = apus_pkg::MAX_AGENTS_DEF,
  parameter int FRACTION_BITS = apus_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [apus_pkg::DIST_W-1:0]  distance_to_goal,
  input  wire logic [apus_pkg::PRIO_W-1:0]  parent_priority,
  input  wire logic                         has_parent,
  input  wire logic [apus_pkg::GROUP_W-1:0] group_size,
  input  wire logic                         last_agent,
  output logic                              result_valid,
  output logic [apus_pkg::IDX_W-1:0]        agent_index,
  output logic [apus_pkg::PRIO_W-1:0]       agent_priority,
  output logic                              last_result
);
  import apus_pkg::*;

  apus_cmd_t    cmd;
  apus_status_t status;

  apus_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .has_parent (has_parent),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  apus_datapath #(
    .MAX_AGENTS    (MAX_AGENTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .distance_to_goal (distance_to_goal),
    .parent_priority  (parent_priority),
    .has_parent       (has_parent),
    .group_size       (group_size),
    .last_agent       (last_agent),
    .result_valid     (result_valid),
    .agent_index      (agent_index),
    .agent_priority   (agent_priority),
    .last_result      (last_result)
  );

`ifndef SYNTHESIS
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("Result strobe without a preceding busy cycle.");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not make the block busy.");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |=> !result_valid)
    else $error("Result strobe continued after the final entry.");
`endif

endmodule

`default_nettype wire
